/* sv/srpg_pkg.sv */
// Shared types and constants of the stepper ramp pulse generator.
package srpg_pkg;

  localparam int OPER_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_W     = 8;

  localparam int MIN_PERIOD_RESET = 500;
  localparam int MAX_PERIOD_RESET = 2000;

  typedef enum logic [OPER_W-1:0] {
    OP_TICK   = 2'd0,
    OP_SLOW   = 2'd1,
    OP_SMOOTH = 2'd2,
    OP_NONE   = 2'd3
  } oper_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_RAMP_ZERO  = 2'd1,
    ST_RAMP_LONG  = 2'd2,
    ST_BUSY       = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_PERIOD = 2'd0,
    CFG_MAX_PERIOD = 2'd1,
    CFG_DRV_ENABLE = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_DIV
  } fsm_t;

endpackage

/* sv/srpg_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
module srpg_div
  import srpg_pkg::*;
#(
  parameter int NUM_W = 20,
  parameter int DEN_W = 24
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  input  logic [DEN_W-1:0] denom,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W:0]   rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;

  // Shift in the next numerator bit and trial-subtract the divisor.
  assign rem_sh = {rem_r[DEN_W-1:0], quo_r[NUM_W-1]};
  assign diff   = rem_sh - {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = numer;
      den_nxt  = denom;
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[DEN_W]) begin
        rem_nxt = diff;
        quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

/* sv/stepper_ramp_pulse_generator.sv */
// Top level of the stepper ramp pulse generator: command decode, pulse timing, ramp.
// A tick, slow move or rejected command is registered at its accepting edge and its
// result word can leave in the next cycle; one word per cycle is sustained while
// out_tready stays high. An accepted smooth move that passes its checks holds in_tready
// low while the divider runs; its result word is registered when the divider finishes.
// Reset (synchronous rst_n low) stops any move, clears out_tvalid, loads periods 500/2000.
module stepper_ramp_pulse_generator
  import srpg_pkg::*;
#(
  parameter int COUNT_WIDTH  = 24,
  parameter int PERIOD_WIDTH = 20
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Command and tick words.
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // tdata, low bit up: pulse_count, ramp_count, move_direction, zero fill
  input  logic [((2*COUNT_WIDTH+8)/8)*8-1:0]    in_tdata,
  // tuser: operation
  input  logic [OPER_W-1:0]                     in_tuser,
  // Result words.
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // tdata, low bit up: step_level, direction_level, enable_n, busy_res,
  // status[1:0], move_done, zero fill
  output logic [OUT_W-1:0]                      out_tdata,
  // Register writes.
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]                  cfg_index,
  input  logic [PERIOD_WIDTH-1:0]               cfg_data
);

  localparam int C = COUNT_WIDTH;
  localparam int P = PERIOD_WIDTH;

  // Configuration registers.
  logic [P-1:0] min_period_r;
  logic [P-1:0] max_period_r;
  logic         drv_enable_r;

  // Move state.
  logic [C-1:0] step_index_r,     step_index_nxt;
  logic [C-1:0] total_steps_r,    total_steps_nxt;
  logic [C-1:0] ramp_steps_r,     ramp_steps_nxt;
  logic [P-1:0] period_delta_r,   period_delta_nxt;
  logic [P-1:0] current_period_r, current_period_nxt;
  logic [P-1:0] tick_count_r,     tick_count_nxt;
  logic         step_out_r,       step_out_nxt;
  logic         dir_out_r,        dir_out_nxt;
  logic         moving_r,         moving_nxt;
  logic         smooth_mode_r,    smooth_mode_nxt;
  fsm_t         state_r,          state_nxt;

  // Smooth command held while the divider runs.
  logic [C-1:0] pend_n_r, pend_n_nxt;
  logic [C-1:0] pend_r_r, pend_r_nxt;
  logic         pend_d_r, pend_d_nxt;

  // Output register.
  logic             out_tvalid_r, out_tvalid_nxt;
  logic [OUT_W-1:0] out_tdata_r,  out_tdata_nxt;

  // Input word fields.
  oper_t        op;
  logic [C-1:0] in_n;
  logic [C-1:0] in_r;
  logic         in_d;
  logic         in_acc;

  // Divider hookup.
  logic         div_start;
  logic         div_done;
  logic [P-1:0] div_numer;
  logic [P-1:0] div_quot;

  // Period update datapath, shared by move start and pulse advance.
  logic         np_smooth;
  logic [C-1:0] np_idx;
  logic [C-1:0] np_ramp;
  logic [C-1:0] np_total;
  logic [P-1:0] np_delta;
  logic [P-1:0] np_base;
  logic [C-1:0] np_thresh;
  logic [P-1:0] np_fall;
  logic [P-1:0] np_period;

  logic [C-1:0] idx_inc;
  logic [P-1:0] tick_inc;
  status_t      status;
  logic         done_flag;
  logic         out_write;

  assign op     = oper_t'(in_tuser);
  assign in_n   = in_tdata[C-1:0];
  assign in_r   = in_tdata[2*C-1:C];
  assign in_d   = in_tdata[2*C];

  // Take a new word only when idle and the output register is free or emptying.
  assign in_tready = (state_r == FSM_IDLE) && (!out_tvalid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign idx_inc  = step_index_r + C'(1);
  assign tick_inc = tick_count_r + P'(1);

  // A reversed period window gives a zero delta: divide zero instead.
  assign div_numer = (max_period_r >= min_period_r) ? (max_period_r - min_period_r) : '0;

  srpg_div #(
    .NUM_W (P),
    .DEN_W (C)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .numer (div_numer),
    .denom (in_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Select the operands of the period update: move start in FSM_DIV or a slow
  // move, next pulse on a tick.
  always_comb begin
    if (state_r == FSM_DIV) begin
      np_smooth = 1'b1;
      np_idx    = '0;
      np_ramp   = pend_r_r;
      np_total  = pend_n_r;
      np_delta  = div_quot;
      np_base   = max_period_r;
    end else begin
      np_smooth = (op == OP_TICK) ? smooth_mode_r : 1'b0;
      np_idx    = idx_inc;
      np_ramp   = ramp_steps_r;
      np_total  = total_steps_r;
      np_delta  = period_delta_r;
      np_base   = (op == OP_TICK) ? current_period_r : max_period_r;
    end
  end

  // Fall by delta inside the leading ramp, rise by delta inside the trailing one.
  assign np_thresh = np_total - np_ramp;
  assign np_fall   = (np_smooth && (np_idx < np_ramp)) ? (np_base - np_delta) : np_base;
  assign np_period = (np_smooth && (np_idx > np_thresh)) ? (np_fall + np_delta) : np_fall;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FSM_IDLE: begin
        if (in_acc && (op == OP_SMOOTH) && !moving_r && (in_r != '0) &&
            (in_r <= (in_n >> 1))) begin
          state_nxt = FSM_DIV;
        end
      end
      FSM_DIV: begin
        if (div_done) begin
          state_nxt = FSM_IDLE;
        end
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  // Move state updates and result word.
  always_comb begin
    step_index_nxt     = step_index_r;
    total_steps_nxt    = total_steps_r;
    ramp_steps_nxt     = ramp_steps_r;
    period_delta_nxt   = period_delta_r;
    current_period_nxt = current_period_r;
    tick_count_nxt     = tick_count_r;
    step_out_nxt       = step_out_r;
    dir_out_nxt        = dir_out_r;
    moving_nxt         = moving_r;
    smooth_mode_nxt    = smooth_mode_r;
    pend_n_nxt         = pend_n_r;
    pend_r_nxt         = pend_r_r;
    pend_d_nxt         = pend_d_r;
    status             = ST_OK;
    done_flag          = 1'b0;
    out_write          = 1'b0;
    div_start          = 1'b0;
    case (state_r)
      FSM_IDLE: begin
        if (in_acc) begin
          out_write = 1'b1;
          case (op)
            OP_TICK: begin
              if (moving_r) begin
                tick_count_nxt = tick_inc;
                if (tick_inc >= current_period_r) begin
                  tick_count_nxt = '0;
                  if (step_out_r) begin
                    step_out_nxt = 1'b0;
                  end else begin
                    step_index_nxt = idx_inc;
                    if (idx_inc >= total_steps_r) begin
                      moving_nxt = 1'b0;
                      done_flag  = 1'b1;
                    end else begin
                      current_period_nxt = np_period;
                      step_out_nxt       = 1'b1;
                    end
                  end
                end
              end
            end
            OP_SLOW: begin
              if (moving_r) begin
                status = ST_BUSY;
              end else begin
                dir_out_nxt        = in_d;
                ramp_steps_nxt     = '0;
                period_delta_nxt   = '0;
                total_steps_nxt    = in_n;
                step_index_nxt     = '0;
                tick_count_nxt     = '0;
                smooth_mode_nxt    = 1'b0;
                current_period_nxt = np_period;
                moving_nxt         = (in_n != '0);
                step_out_nxt       = (in_n != '0);
              end
            end
            OP_SMOOTH: begin
              if (moving_r) begin
                status = ST_BUSY;
              end else if (in_r == '0) begin
                status = ST_RAMP_ZERO;
              end else if (in_r > (in_n >> 1)) begin
                status = ST_RAMP_LONG;
              end else begin
                // Hold the command and start the divider; the result comes later.
                out_write  = 1'b0;
                div_start  = 1'b1;
                pend_n_nxt = in_n;
                pend_r_nxt = in_r;
                pend_d_nxt = in_d;
              end
            end
            default: begin
            end
          endcase
        end
      end
      FSM_DIV: begin
        if (div_done) begin
          // Count is at least two here, so the move always starts.
          out_write          = 1'b1;
          dir_out_nxt        = pend_d_r;
          ramp_steps_nxt     = pend_r_r;
          period_delta_nxt   = div_quot;
          total_steps_nxt    = pend_n_r;
          step_index_nxt     = '0;
          tick_count_nxt     = '0;
          smooth_mode_nxt    = 1'b1;
          current_period_nxt = np_period;
          moving_nxt         = 1'b1;
          step_out_nxt       = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_tvalid_nxt = out_write || (out_tvalid_r && !out_tready);
    out_tdata_nxt  = out_tdata_r;
    if (out_write) begin
      out_tdata_nxt = {1'b0, done_flag, status, moving_nxt, ~drv_enable_r,
                       dir_out_nxt, step_out_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_period_r     <= P'(MIN_PERIOD_RESET);
      max_period_r     <= P'(MAX_PERIOD_RESET);
      drv_enable_r     <= 1'b0;
      step_index_r     <= '0;
      total_steps_r    <= '0;
      ramp_steps_r     <= '0;
      period_delta_r   <= '0;
      current_period_r <= '0;
      tick_count_r     <= '0;
      step_out_r       <= 1'b0;
      dir_out_r        <= 1'b0;
      moving_r         <= 1'b0;
      smooth_mode_r    <= 1'b0;
      state_r          <= FSM_IDLE;
      out_tvalid_r     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_MIN_PERIOD: min_period_r <= cfg_data;
          CFG_MAX_PERIOD: max_period_r <= cfg_data;
          CFG_DRV_ENABLE: drv_enable_r <= cfg_data[0];
          default: begin
          end
        endcase
      end
      step_index_r     <= step_index_nxt;
      total_steps_r    <= total_steps_nxt;
      ramp_steps_r     <= ramp_steps_nxt;
      period_delta_r   <= period_delta_nxt;
      current_period_r <= current_period_nxt;
      tick_count_r     <= tick_count_nxt;
      step_out_r       <= step_out_nxt;
      dir_out_r        <= dir_out_nxt;
      moving_r         <= moving_nxt;
      smooth_mode_r    <= smooth_mode_nxt;
      state_r          <= state_nxt;
      out_tvalid_r     <= out_tvalid_nxt;
    end
    pend_n_r    <= pend_n_nxt;
    pend_r_r    <= pend_r_nxt;
    pend_d_r    <= pend_d_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef SYNTHESIS
  a_no_accept_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FSM_DIV) |-> !in_tready)
    else $error("input accepted while divider runs");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == FSM_DIV))
    else $error("divider finished outside of smooth move setup");

  a_moving_has_steps: assert property (@(posedge clk) disable iff (!rst_n)
    moving_r |-> (total_steps_r != '0))
    else $error("move running with zero pulse count");

  a_tick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    moving_r |-> ((tick_count_r < current_period_r) || (tick_count_r == '0)))
    else $error("tick count passed the half-period");

  a_div_result_out: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == FSM_DIV) && div_done) |=> (out_tvalid && moving_r))
    else $error("smooth move start not reported");
`endif

endmodule

/* tb/tb_stepper_ramp_pulse_generator.sv */
// Self-checking testbench for the stepper ramp pulse generator: stream stimulus and scoreboard.
`timescale 1ns / 100ps

module tb_stepper_ramp_pulse_generator
  import srpg_pkg::*;
();

  localparam int CNT_W     = 24;
  localparam int PER_W     = 20;
  localparam int IN_DW     = ((2*CNT_W+8)/8)*8;
  localparam int PRESS_LEN = 400;   // long receiver hold-off, in cycles
  localparam int IDLE_MAX  = 5000;  // watchdog: cycles without any handshake

  // One command or tick word as queued for the driver.
  typedef struct {
    oper_t            op;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] ramp;
    logic             dir;
  } cmd_word_t;

  // Pin levels and status reported in one result word.
  typedef struct packed {
    logic    step;
    logic    dir;
    logic    en_n;
    logic    busy;
    status_t status;
    logic    done;
  } pin_word_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_DW-1:0] in_tdata = '0;
  logic [OPER_W-1:0] in_tuser = OP_TICK;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_MIN_PERIOD;
  logic [PER_W-1:0] cfg_data = '0;

  stepper_ramp_pulse_generator #(
    .COUNT_WIDTH  (CNT_W),
    .PERIOD_WIDTH (PER_W)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Pulse generator predictor: register copy and move state, reset values.
  // ---------------------------------------------------------------------------
  logic [PER_W-1:0] cfg_min = PER_W'(MIN_PERIOD_RESET);
  logic [PER_W-1:0] cfg_max = PER_W'(MAX_PERIOD_RESET);
  logic             cfg_en  = 1'b0;

  logic [CNT_W-1:0] g_index  = '0;
  logic [CNT_W-1:0] g_total  = '0;
  logic [CNT_W-1:0] g_ramp   = '0;
  logic [PER_W-1:0] g_delta  = '0;
  logic [PER_W-1:0] g_period = '0;
  logic [PER_W-1:0] g_ticks  = '0;
  logic             g_step   = 1'b0;
  logic             g_dir    = 1'b0;
  logic             g_moving = 1'b0;
  logic             g_smooth = 1'b0;

  // Derive the half-period of pulse g_index from the previous one. The ramp is
  // lopsided on purpose: ramp steps down, one fewer step up.
  function automatic void ramp_period();
    if (!g_smooth) return;
    if (g_index < g_ramp) g_period = g_period - g_delta;
    // Compare in 32 bits so a wrapped difference stays large.
    if ({8'd0, g_index} > ({8'd0, g_total} - {8'd0, g_ramp}))
      g_period = g_period + g_delta;
  endfunction

  // Latch a new move; an empty move just drops the step line.
  function automatic void launch(input logic [CNT_W-1:0] n, input logic smooth);
    g_total  = n;
    g_index  = '0;
    g_ticks  = '0;
    g_smooth = smooth;
    g_period = cfg_max;
    if (n == '0) begin
      g_moving = 1'b0;
      g_step   = 1'b0;
      return;
    end
    ramp_period();
    g_moving = 1'b1;
    g_step   = 1'b1;
  endfunction

  // Apply one accepted word and return the pin levels it should produce.
  function automatic pin_word_t pulse_gen_apply(input oper_t op, input logic [CNT_W-1:0] n,
                                                input logic [CNT_W-1:0] r, input logic d);
    pin_word_t w;
    status_t   st;
    logic      done;
    st   = ST_OK;
    done = 1'b0;
    case (op)
      OP_TICK: begin
        // Ticks only count while a move runs.
        if (g_moving) begin
          g_ticks = g_ticks + PER_W'(1);
          if (g_ticks >= g_period) begin
            g_ticks = '0;
            if (g_step) begin
              g_step = 1'b0;
            end else begin
              g_index = g_index + CNT_W'(1);
              if (g_index >= g_total) begin
                g_moving = 1'b0;
                done     = 1'b1;
              end else begin
                ramp_period();
                g_step = 1'b1;
              end
            end
          end
        end
      end
      OP_SLOW, OP_SMOOTH: begin
        // Busy check wins over every other rejection.
        if (g_moving) begin
          st = ST_BUSY;
        end else if (op == OP_SLOW) begin
          g_dir   = d;
          g_ramp  = '0;
          g_delta = '0;
          launch(n, 1'b0);
        end else if (r == '0) begin
          st = ST_RAMP_ZERO;
        end else if (r > (n >> 1)) begin
          st = ST_RAMP_LONG;
        end else begin
          g_dir   = d;
          g_ramp  = r;
          g_delta = (cfg_max >= cfg_min) ? PER_W'(CNT_W'(cfg_max - cfg_min) / r) : '0;
          launch(n, 1'b1);
        end
      end
      default: ;
    endcase
    w.step   = g_step;
    w.dir    = g_dir;
    w.en_n   = ~cfg_en;
    w.busy   = g_moving;
    w.status = st;
    w.done   = done;
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus queue, driver and idle pattern of the sender.
  // ---------------------------------------------------------------------------
  cmd_word_t cmd_pending[$];
  pin_word_t pin_word_q[$];
  int        item_total = 0;
  int        acc_count = 0;
  int        in_gap_left = 0;
  int        out_stall_left = 0;
  int        rx_pick = 0;
  logic      in_fire = 1'b0;
  logic      in_quiet = 1'b0;
  logic      out_quiet = 1'b0;
  logic      press_req = 1'b0;
  logic      press_seen = 1'b0;
  int        press_left = 0;
  int        err_count = 0;
  int        idle_cycles = 0;
  pin_word_t mon_got;
  pin_word_t mon_want;

  // Idle length: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 16);
    return $urandom_range(40, 150);
  endfunction

  function automatic logic [CNT_W-1:0] rnd24();
    return CNT_W'($urandom);
  endfunction

  // Record acceptance and predict the result word at the same edge.
  always @(posedge clk) begin
    in_fire <= in_tvalid && in_tready;
    if (in_tvalid && in_tready) begin
      acc_count <= acc_count + 1;
      pin_word_q.push_back(pulse_gen_apply(oper_t'(in_tuser), in_tdata[CNT_W-1:0],
                                           in_tdata[2*CNT_W-1:CNT_W], in_tdata[2*CNT_W]));
    end
  end

  // Driver: hold an offered word until taken, then idle or present the next.
  always @(negedge clk) begin
    if (in_tvalid && !in_fire) begin
      // hold the current word
    end else if (in_gap_left != 0) begin
      in_tvalid   <= 1'b0;
      in_gap_left <= in_gap_left - 1;
    end else if (cmd_pending.size() != 0) begin
      in_tdata    <= {7'd0, cmd_pending[0].dir, cmd_pending[0].ramp, cmd_pending[0].count};
      in_tuser    <= cmd_pending[0].op;
      in_tvalid   <= 1'b1;
      in_gap_left <= in_quiet ? 0 : pick_gap();
      void'(cmd_pending.pop_front());
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Long hold-off of the receiver, counted here once requested.
  always @(posedge clk) begin
    if (press_req && !press_seen) begin
      press_seen <= 1'b1;
      press_left <= PRESS_LEN;
    end else if (press_left != 0) begin
      press_left <= press_left - 1;
    end
  end

  // Receiver ready pattern: random stalls unless quiet or held off.
  always @(negedge clk) begin
    if (press_left != 0) begin
      out_tready <= 1'b0;
    end else if (out_stall_left != 0) begin
      out_tready     <= 1'b0;
      out_stall_left <= out_stall_left - 1;
    end else if (out_quiet) begin
      out_tready <= 1'b1;
    end else begin
      rx_pick = pick_gap();
      if (rx_pick == 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready     <= 1'b0;
        out_stall_left <= rx_pick - 1;
      end
    end
  end

  // Scoreboard: each result word against the oldest prediction.
  always @(posedge clk) begin
    if (out_tvalid && out_tready) begin
      mon_got.step   = out_tdata[0];
      mon_got.dir    = out_tdata[1];
      mon_got.en_n   = out_tdata[2];
      mon_got.busy   = out_tdata[3];
      mon_got.status = status_t'(out_tdata[5:4]);
      mon_got.done   = out_tdata[6];
      if (pin_word_q.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("%0t: result word with nothing predicted: %b", $realtime, out_tdata);
      end else begin
        mon_want = pin_word_q.pop_front();
        if (mon_got.step !== mon_want.step || mon_got.dir !== mon_want.dir ||
            mon_got.en_n !== mon_want.en_n || mon_got.busy !== mon_want.busy ||
            mon_got.status !== mon_want.status || mon_got.done !== mon_want.done) begin
          err_count++;
          // Fields in order: step dir en_n busy, then status and done.
          if (err_count <= 10)
            $display("%0t: mismatch exp %b%b%b%b %0d %b got %b%b%b%b %0d %b", $realtime,
                     mon_want.step, mon_want.dir, mon_want.en_n, mon_want.busy,
                     mon_want.status, mon_want.done, mon_got.step, mon_got.dir,
                     mon_got.en_n, mon_got.busy, mon_got.status, mon_got.done);
        end
      end
    end
  end

  // Watchdog: stop a run in which no handshake completes for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_MAX) begin
        $display("tb_stepper_ramp_pulse_generator: done, errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing helpers.
  // ---------------------------------------------------------------------------
  task automatic push_item(input oper_t op, input logic [CNT_W-1:0] n,
                           input logic [CNT_W-1:0] r, input logic d);
    cmd_word_t c;
    c.op    = op;
    c.count = n;
    c.ramp  = r;
    c.dir   = d;
    cmd_pending.push_back(c);
    item_total++;
  endtask

  // Ticks carry random payload; the block must ignore it.
  task automatic push_ticks(input int k);
    for (int i = 0; i < k; i++)
      push_item(OP_TICK, rnd24(), rnd24(), 1'($urandom_range(0, 1)));
  endtask

  // Wait until every queued word went in and every result came back.
  task automatic drain();
    while (acc_count != item_total || pin_word_q.size() != 0)
      @(negedge clk);
  endtask

  // Register write; only called while the stream is drained.
  task automatic cfg_write(input cfg_idx_t idx, input logic [PER_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_MIN_PERIOD: cfg_min = val;
      CFG_MAX_PERIOD: cfg_max = val;
      CFG_DRV_ENABLE: cfg_en  = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One well-formed move with random content, followed by enough ticks to
  // finish it (sometimes cut short), sprinkled with noise and busy probes.
  task automatic add_move_seq();
    oper_t            op;
    logic [CNT_W-1:0] n;
    logic [CNT_W-1:0] r;
    logic [CNT_W-1:0] nn;
    int               bound;
    int               k;
    if ($urandom_range(0, 1)) begin
      op = OP_SLOW;
      n  = CNT_W'($urandom_range(0, 10));
      r  = rnd24();
    end else begin
      op = OP_SMOOTH;
      n  = CNT_W'($urandom_range(2, 10));
      r  = CNT_W'($urandom_range(1, n / 2));
    end
    push_item(op, n, r, 1'($urandom_range(0, 1)));
    // Probe with a small move right away; expected to bounce as busy.
    if (n != '0 && $urandom_range(0, 3) == 0) begin
      nn = CNT_W'($urandom_range(2, 10));
      push_item($urandom_range(0, 1) ? OP_SLOW : OP_SMOOTH, nn,
                CNT_W'($urandom_range(1, nn / 2)), 1'($urandom_range(0, 1)));
    end
    // No half-period exceeds max_period here; zero behaves as one tick.
    bound = 2 * n * ((cfg_max == '0) ? 1 : cfg_max);
    k = ($urandom_range(0, 6) == 0) ? $urandom_range(0, bound) : bound + $urandom_range(0, 3);
    for (int i = 0; i < k; i++) begin
      if ($urandom_range(0, 24) == 0) begin
        if ($urandom_range(0, 1)) begin
          push_item(OP_NONE, rnd24(), rnd24(), 1'($urandom_range(0, 1)));
        end else begin
          // Smooth move that can never be taken: zero or overlong ramp.
          nn = rnd24();
          push_item(OP_SMOOTH, nn,
                    ($urandom_range(0, 2) == 0) ? '0 :
                    (nn >> 1) + CNT_W'(1) + (rnd24() & 24'h7F_FFFF),
                    1'($urandom_range(0, 1)));
        end
      end
      push_ticks(1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  int phase_start;

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset registers: an idle tick, unused op, empty slow move, ramp rejections.
    push_ticks(1);
    push_item(OP_NONE, rnd24(), rnd24(), 1'b1);
    push_item(OP_SLOW, '0, rnd24(), 1'b1);
    push_item(OP_SMOOTH, 24'd10, '0, 1'b0);
    push_item(OP_SMOOTH, 24'd10, 24'd6, 1'b0);
    push_item(OP_SMOOTH, 24'hFF_FFFF, 24'hFF_FFFF, 1'b0);
    push_item(OP_SMOOTH, '0, '0, 1'b1);
    drain();

    // Short ramped move; busy commands must leave the direction alone.
    cfg_write(CFG_MIN_PERIOD, 20'd1);
    cfg_write(CFG_MAX_PERIOD, 20'd3);
    cfg_write(CFG_DRV_ENABLE, 20'd1);
    push_item(OP_SMOOTH, 24'd4, 24'd2, 1'b0);
    push_item(OP_SLOW, 24'd3, '0, 1'b1);
    push_item(OP_SMOOTH, 24'd6, '0, 1'b1);
    push_ticks(14);
    drain();

    // Random phases with fresh small periods each time.
    for (int p = 0; p < 6; p++) begin
      cfg_write(CFG_MIN_PERIOD, PER_W'($urandom_range(1, 6)));
      cfg_write(CFG_MAX_PERIOD, PER_W'($urandom_range(1, 12)));
      cfg_write(CFG_DRV_ENABLE, PER_W'($urandom_range(0, 1)));
      if (p == 1) cfg_write(CFG_UNUSED, PER_W'($urandom));
      in_quiet  = (p == 2) || (p == 4);
      out_quiet = (p == 2);
      // Hold the receiver off; the input stalls once the output register fills.
      if (p == 3) press_req = 1'b1;
      phase_start = item_total;
      while (item_total - phase_start < 160) add_move_seq();
      // Flush any move left running before the extreme settings.
      if (p == 5) push_ticks(300);
      drain();
    end
    in_quiet  = 1'b0;
    out_quiet = 1'b0;

    // Zero half-period with max below min: flat ramp, toggle every tick.
    cfg_write(CFG_MIN_PERIOD, 20'd1000000);
    cfg_write(CFG_MAX_PERIOD, 20'd0);
    cfg_write(CFG_DRV_ENABLE, 20'd0);
    push_item(OP_SMOOTH, 24'd4, 24'd2, 1'b1);
    push_ticks(10);
    push_item(OP_SLOW, 24'd3, rnd24(), 1'b0);
    push_ticks(8);
    drain();

    // Period span from 1 to 1000000: steepest delta, then a move too long to finish.
    cfg_write(CFG_MIN_PERIOD, 20'd1);
    cfg_write(CFG_MAX_PERIOD, 20'd1000000);
    cfg_write(CFG_DRV_ENABLE, 20'd1);
    push_item(OP_SMOOTH, 24'd2, 24'd1, 1'b1);
    push_ticks(6);
    push_item(OP_SLOW, 24'hFF_FFFF, rnd24(), 1'b0);
    push_ticks(5);
    push_item(OP_SMOOTH, 24'hFF_FFFF, 24'd1, 1'b1);
    push_ticks(3);
    drain();

    // Let any stray word show up before judging.
    repeat (30) @(posedge clk);
    if (err_count == 0 && pin_word_q.size() == 0)
      $display("tb_stepper_ramp_pulse_generator: done, clean");
    else
      $display("tb_stepper_ramp_pulse_generator: done, errors");
    $finish;
  end

endmodule

/* filelist.f */
sv/srpg_pkg.sv
sv/srpg_div.sv
sv/stepper_ramp_pulse_generator.sv
tb/tb_stepper_ramp_pulse_generator.sv
